// ===== design/mchc_pkg.sv =====
// ----------------------------------------------------------------------------
// mchc_pkg
// Shared widths, limits and register indexes for the multi-click classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package mchc_pkg;

    localparam int TIME_W      = 32;
    localparam int MS_W        = 16;
    localparam int COUNT_W     = 4;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    localparam logic [COUNT_W-1:0] MAX_CLICKS = 4'd8;
    localparam logic [COUNT_W-1:0] MAX_HOLDS  = 4'd8;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_HIGH = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_MS = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_MS     = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_GAP_MS      = 4'd3;

    // reset values of the registers
    localparam logic            RST_ACTIVE_HIGH = 1'b1;
    localparam logic [MS_W-1:0] RST_DEBOUNCE_MS = 16'd50;
    localparam logic [MS_W-1:0] RST_HOLD_MS     = 16'd1000;
    localparam logic [MS_W-1:0] RST_GAP_MS      = 16'd300;

endpackage

`default_nettype wire

// ===== design/mchc_if.sv =====
// ----------------------------------------------------------------------------
// mchc_if
// Valid/ready channels: poll words in, result words out, register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface mchc_poll_if;
    logic                          valid;
    logic                          ready;
    logic                          raw_level;
    logic [mchc_pkg::TIME_W-1:0]   now_ms;

    modport source (output valid, output raw_level, output now_ms, input ready);
    modport sink   (input valid, input raw_level, input now_ms, output ready);
endinterface

interface mchc_result_if;
    logic                          valid;
    logic                          ready;
    logic                          click_fire;
    logic [mchc_pkg::COUNT_W-1:0]  click_total;
    logic                          hold_fire;
    logic [mchc_pkg::COUNT_W-1:0]  hold_total;

    modport source (output valid, output click_fire, output click_total,
                    output hold_fire, output hold_total, input ready);
    modport sink   (input valid, input click_fire, input click_total,
                    input hold_fire, input hold_total, output ready);
endinterface

interface mchc_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [mchc_pkg::CFG_INDEX_W-1:0]  index;
    logic [mchc_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/multi_click_hold_classifier.sv =====
// ----------------------------------------------------------------------------
// multi_click_hold_classifier
// Counts clicks and holds of one button and reports each finished sequence.
// ----------------------------------------------------------------------------
// Every poll word (pin level plus millisecond time) yields exactly one result
// word through the input and result registers. A new poll is taken every
// clock unless the result register is stalled: the poll word is held in an
// input register, one pass of compare, subtract and add logic updates the
// press state and fills the result register. Throughput is one word per
// cycle, limited only by the result register draining. Register writes are
// always accepted and must only be issued while no poll is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_click_hold_classifier (
    input  wire                 clk,
    input  wire                 rst_n,
    mchc_poll_if.sink           poll,
    mchc_result_if.source       result,
    mchc_cfg_if.sink            cfg
);

    localparam int TW = mchc_pkg::TIME_W;
    localparam int CW = mchc_pkg::COUNT_W;

    // configuration registers
    logic                     active_high_reg;
    logic [mchc_pkg::MS_W-1:0] debounce_ms_reg;
    logic [mchc_pkg::MS_W-1:0] hold_ms_reg;
    logic [mchc_pkg::MS_W-1:0] gap_ms_reg;

    // input stage
    logic          in_valid_reg;
    logic          in_level_reg;
    logic [TW-1:0] in_now_reg;

    // press tracking state
    logic          pressed_level_reg,  pressed_level_next;
    logic [TW-1:0] press_start_reg,    press_start_next;
    logic [TW-1:0] release_time_reg,   release_time_next;
    logic [CW-1:0] pending_clicks_reg, pending_clicks_next;
    logic [CW-1:0] pending_holds_reg,  pending_holds_next;
    logic [TW-1:0] last_click_end_reg, last_click_end_next;
    logic [TW-1:0] last_hold_end_reg,  last_hold_end_next;

    // result stage
    logic          out_valid_reg;
    logic          click_fire_reg,  click_fire_next;
    logic [CW-1:0] click_total_reg, click_total_next;
    logic          hold_fire_reg,   hold_fire_next;
    logic [CW-1:0] hold_total_reg,  hold_total_next;

    // handshake: advance the input word whenever the result slot is free
    logic advance;
    logic fire;

    assign advance    = !out_valid_reg || result.ready;
    assign fire       = in_valid_reg && advance;
    assign poll.ready = !in_valid_reg || advance;
    assign cfg.ready  = 1'b1;

    // ------------------------------------------------------------------
    // Register writes; indexes beyond the list are dropped.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_high_reg <= mchc_pkg::RST_ACTIVE_HIGH;
            debounce_ms_reg <= mchc_pkg::RST_DEBOUNCE_MS;
            hold_ms_reg     <= mchc_pkg::RST_HOLD_MS;
            gap_ms_reg      <= mchc_pkg::RST_GAP_MS;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                mchc_pkg::REG_ACTIVE_HIGH: active_high_reg <= cfg.data[0];
                mchc_pkg::REG_DEBOUNCE_MS: debounce_ms_reg <= cfg.data;
                mchc_pkg::REG_HOLD_MS:     hold_ms_reg     <= cfg.data;
                mchc_pkg::REG_GAP_MS:      gap_ms_reg      <= cfg.data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register: hold the poll word until it moves to the result.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (poll.ready)
            in_valid_reg <= poll.valid;
    end

    always_ff @(posedge clk)
    begin
        if (poll.valid && poll.ready)
        begin
            in_level_reg <= poll.raw_level;
            in_now_reg   <= poll.now_ms;
        end
    end

    // ------------------------------------------------------------------
    // One pass of classification over the held poll word.
    // ------------------------------------------------------------------
    logic          cur_pressed;
    logic          level_change;
    logic          measured;
    logic [TW-1:0] press_len;
    logic          counted;
    logic          is_click;
    logic          is_hold;
    logic [TW-1:0] click_deadline;
    logic [TW-1:0] hold_deadline;
    logic          click_due;
    logic          hold_due;

    always_comb
    begin
        cur_pressed  = (in_level_reg == active_high_reg);
        level_change = (cur_pressed != pressed_level_reg);

        pressed_level_next = level_change ? cur_pressed : pressed_level_reg;
        press_start_next   = (level_change && cur_pressed)  ? in_now_reg : press_start_reg;
        release_time_next  = (level_change && !cur_pressed) ? in_now_reg : release_time_reg;

        // a press is measured only when the off time lies after the on time
        measured  = level_change && (release_time_next > press_start_next);
        press_len = release_time_next - press_start_next;
        counted   = measured && (press_len > TW'(debounce_ms_reg));
        is_click  = counted && (press_len < TW'(hold_ms_reg));
        is_hold   = counted && !is_click;

        pending_clicks_next = pending_clicks_reg;
        last_click_end_next = last_click_end_reg;
        if (is_click)
        begin
            if (pending_clicks_reg < mchc_pkg::MAX_CLICKS)
                pending_clicks_next = pending_clicks_reg + CW'(1);
            last_click_end_next = release_time_next;
        end

        pending_holds_next = pending_holds_reg;
        last_hold_end_next = last_hold_end_reg;
        if (is_hold)
        begin
            if (pending_holds_reg < mchc_pkg::MAX_HOLDS)
                pending_holds_next = pending_holds_reg + CW'(1);
            last_hold_end_next = release_time_next;
        end

        // gap test: the sum wraps modulo 2^32 on purpose
        click_deadline = last_click_end_next + TW'(gap_ms_reg);
        hold_deadline  = last_hold_end_next + TW'(gap_ms_reg);
        click_due = (pending_clicks_next != '0) && (click_deadline < in_now_reg);
        hold_due  = (pending_holds_next != '0) && (hold_deadline < in_now_reg);

        click_fire_next  = click_due;
        click_total_next = click_due ? pending_clicks_next : '0;
        hold_fire_next   = hold_due;
        hold_total_next  = hold_due ? pending_holds_next : '0;

        // drop a count once it is reported
        if (click_due)
            pending_clicks_next = '0;
        if (hold_due)
            pending_holds_next = '0;
    end

    // ------------------------------------------------------------------
    // Press state advances only when a poll word is retired.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_level_reg  <= 1'b0;
            press_start_reg    <= '0;
            release_time_reg   <= '0;
            pending_clicks_reg <= '0;
            pending_holds_reg  <= '0;
            last_click_end_reg <= '0;
            last_hold_end_reg  <= '0;
        end
        else if (fire)
        begin
            pressed_level_reg  <= pressed_level_next;
            press_start_reg    <= press_start_next;
            release_time_reg   <= release_time_next;
            pending_clicks_reg <= pending_clicks_next;
            pending_holds_reg  <= pending_holds_next;
            last_click_end_reg <= last_click_end_next;
            last_hold_end_reg  <= last_hold_end_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register: hold the word while the sink stalls.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            click_fire_reg  <= click_fire_next;
            click_total_reg <= click_total_next;
            hold_fire_reg   <= hold_fire_next;
            hold_total_reg  <= hold_total_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.click_fire  = click_fire_reg;
    assign result.click_total = click_total_reg;
    assign result.hold_fire   = hold_fire_reg;
    assign result.hold_total  = hold_total_reg;

endmodule

`default_nettype wire

// ===== design/mchc_checker.sv =====
// ----------------------------------------------------------------------------
// mchc_checker
// Port-level checks on the result channel of the classifier.
// ----------------------------------------------------------------------------
`default_nettype none

module mchc_checker (
    input wire                          clk,
    input wire                          rst_n,
    input wire                          res_valid,
    input wire                          res_ready,
    input wire                          click_fire,
    input wire [mchc_pkg::COUNT_W-1:0]  click_total,
    input wire                          hold_fire,
    input wire [mchc_pkg::COUNT_W-1:0]  hold_total
);

    // a click report carries a count in range, no report carries zero
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (click_fire ? (click_total != '0 &&
                                     click_total <= mchc_pkg::MAX_CLICKS)
                                  : (click_total == '0)))
        else $error("click count inconsistent with click_fire");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (hold_fire ? (hold_total != '0 &&
                                    hold_total <= mchc_pkg::MAX_HOLDS)
                                 : (hold_total == '0)))
        else $error("hold count inconsistent with hold_fire");

    // a stalled result word stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(click_fire) &&
            $stable(click_total) && $stable(hold_fire) && $stable(hold_total)))
        else $error("result word changed while stalled");

    // no result right out of reset
    assert property (@(posedge clk) $rose(rst_n) |-> !res_valid)
        else $error("result valid right after reset");

endmodule

bind multi_click_hold_classifier mchc_checker u_mchc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .click_fire  (result.click_fire),
    .click_total (result.click_total),
    .hold_fire   (result.hold_fire),
    .hold_total  (result.hold_total)
);

`default_nettype wire

// ===== bench/mchc_report_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mchc_report_checker
// Watches the poll, result and register channels of the click classifier,
// predicts the report word for every accepted poll word and compares it.
// ----------------------------------------------------------------------------
module mchc_report_checker
    import mchc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    mchc_poll_if    poll,
    mchc_result_if  result,
    mchc_cfg_if     cfg,
    output int      errors,
    output int      awaiting,
    output int      checked,
    output int      click_reports,
    output int      hold_reports,
    output int      dual_reports
);

    typedef struct packed {
        logic               click_fire;
        logic [COUNT_W-1:0] click_total;
        logic               hold_fire;
        logic [COUNT_W-1:0] hold_total;
    } report_t;

    // register copies
    logic            pol_high = RST_ACTIVE_HIGH;
    logic [MS_W-1:0] debounce = RST_DEBOUNCE_MS;
    logic [MS_W-1:0] hold_thr = RST_HOLD_MS;
    logic [MS_W-1:0] gap      = RST_GAP_MS;

    // button state
    logic               btn_down    = 1'b0;
    logic [TIME_W-1:0]  down_at     = '0;
    logic [TIME_W-1:0]  up_at       = '0;
    logic [TIME_W-1:0]  click_end   = '0;
    logic [TIME_W-1:0]  hold_end    = '0;
    logic [COUNT_W-1:0] click_count = '0;
    logic [COUNT_W-1:0] hold_count  = '0;

    report_t due_reports[$];

    int mismatch_count = 0;
    int result_count   = 0;
    int click_count_rp = 0;
    int hold_count_rp  = 0;
    int dual_count_rp  = 0;

    // Advance the button state by one poll and queue the report it causes.
    task automatic classify_poll(input logic level, input logic [TIME_W-1:0] now);
        logic              pressed;
        logic [TIME_W-1:0] span;
        logic [TIME_W-1:0] deadline;
        report_t           rep;
        rep = '0;
        pressed = (level == pol_high);
        if (pressed != btn_down)
        begin
            btn_down = pressed;
            if (pressed)
                down_at = now;
            else
                up_at = now;
            // measure on either change; only an off time after the on time counts
            if (up_at > down_at)
            begin
                span = up_at - down_at;
                if (span > {{(TIME_W-MS_W){1'b0}}, debounce})
                begin
                    if (span < {{(TIME_W-MS_W){1'b0}}, hold_thr})
                    begin
                        if (click_count < MAX_CLICKS)
                            click_count = click_count + COUNT_W'(1);
                        click_end = up_at;
                    end
                    else
                    begin
                        if (hold_count < MAX_HOLDS)
                            hold_count = hold_count + COUNT_W'(1);
                        hold_end = up_at;
                    end
                end
            end
        end
        deadline = click_end + {{(TIME_W-MS_W){1'b0}}, gap};
        if (click_count != '0 && deadline < now)
        begin
            rep.click_fire  = 1'b1;
            rep.click_total = click_count;
            click_count     = '0;
        end
        deadline = hold_end + {{(TIME_W-MS_W){1'b0}}, gap};
        if (hold_count != '0 && deadline < now)
        begin
            rep.hold_fire  = 1'b1;
            rep.hold_total = hold_count;
            hold_count     = '0;
        end
        due_reports.push_back(rep);
    endtask

    task automatic compare_field(input string field, input logic [31:0] want, got);
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        report_t want;
        if (!rst_n)
        begin
            pol_high    = RST_ACTIVE_HIGH;
            debounce    = RST_DEBOUNCE_MS;
            hold_thr    = RST_HOLD_MS;
            gap         = RST_GAP_MS;
            btn_down    = 1'b0;
            down_at     = '0;
            up_at       = '0;
            click_end   = '0;
            hold_end    = '0;
            click_count = '0;
            hold_count  = '0;
            due_reports.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_ACTIVE_HIGH: pol_high = cfg.data[0];
                    REG_DEBOUNCE_MS: debounce = cfg.data;
                    REG_HOLD_MS:     hold_thr = cfg.data;
                    REG_GAP_MS:      gap      = cfg.data;
                    default: ;
                endcase
            end
            if (poll.valid && poll.ready)
                classify_poll(poll.raw_level, poll.now_ms);
            if (result.valid && result.ready)
            begin
                if (due_reports.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: result word with none expected, %s %0b/%0d hold %0b/%0d",
                             $time, "got click", result.click_fire, result.click_total,
                             result.hold_fire, result.hold_total);
                end
                else
                begin
                    want = due_reports.pop_front();
                    result_count++;
                    compare_field("click_fire",  32'(want.click_fire),
                                  32'(result.click_fire));
                    compare_field("click_total", 32'(want.click_total),
                                  32'(result.click_total));
                    compare_field("hold_fire",   32'(want.hold_fire),
                                  32'(result.hold_fire));
                    compare_field("hold_total",  32'(want.hold_total),
                                  32'(result.hold_total));
                    if (want.click_fire)
                        click_count_rp++;
                    if (want.hold_fire)
                        hold_count_rp++;
                    if (want.click_fire && want.hold_fire)
                        dual_count_rp++;
                end
            end
        end
        errors        <= mismatch_count;
        awaiting      <= due_reports.size();
        checked       <= result_count;
        click_reports <= click_count_rp;
        hold_reports  <= hold_count_rp;
        dual_reports  <= dual_count_rp;
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives button polls and register settings into the click classifier; the
// checker beside the block predicts every report word and counts mismatches.
// ----------------------------------------------------------------------------
module testbench;
    import mchc_pkg::*;

    localparam int HOLDOFF_CYCLES = 150;
    localparam int PHASES         = 8;
    localparam int PHASE_POLLS    = 155;

    logic clk = 1'b0;
    logic rst_n;

    mchc_poll_if   poll();
    mchc_result_if result();
    mchc_cfg_if    cfg();

    int errors;
    int awaiting;
    int checked;
    int click_reports;
    int hold_reports;
    int dual_reports;

    // stimulus-side copy of the current setting, used to shape presses
    logic              pol_set      = RST_ACTIVE_HIGH;
    int unsigned       debounce_set = 32'(RST_DEBOUNCE_MS);
    int unsigned       hold_set     = 32'(RST_HOLD_MS);
    int unsigned       gap_set      = 32'(RST_GAP_MS);
    logic [TIME_W-1:0] wall_ms      = '0;

    int polls_sent       = 0;
    int settings_applied = 0;

    // handshake pacing controls shared by the two sides
    bit steady_source = 1'b0;
    bit steady_sink   = 1'b0;
    bit long_holdoff  = 1'b0;

    multi_click_hold_classifier DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .poll   (poll),
        .result (result),
        .cfg    (cfg)
    );

    mchc_report_checker checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .poll          (poll),
        .result        (result),
        .cfg           (cfg),
        .errors        (errors),
        .awaiting      (awaiting),
        .checked       (checked),
        .click_reports (click_reports),
        .hold_reports  (hold_reports),
        .dual_reports  (dual_reports)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int unsigned idle_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    // Pin level that means pressed or released under the current polarity.
    function automatic logic pin_for(input logic pressed);
        return pressed ? pol_set : ~pol_set;
    endfunction

    // Pick a press length: bounces, clicks and holds, often right on a limit.
    function automatic int unsigned press_length();
        int unsigned kind;
        int unsigned lo;
        bit          at_limit;
        kind     = $urandom_range(0, 99);
        at_limit = ($urandom_range(0, 3) == 0);
        if (kind < 20)
            return at_limit ? debounce_set : $urandom_range(0, debounce_set);
        if (kind < 75 && hold_set > debounce_set + 1)
        begin
            if (at_limit)
                return $urandom_range(0, 1) ? debounce_set + 1 : hold_set - 1;
            return $urandom_range(debounce_set + 1, hold_set - 1);
        end
        lo = (hold_set > debounce_set) ? hold_set : debounce_set + 1;
        return at_limit ? lo : lo + $urandom_range(0, 3000);
    endfunction

    // Offer one poll word, hold it until accepted, then maybe idle.
    task automatic send_poll(input logic level, input logic [TIME_W-1:0] at);
        int unsigned gap;
        poll.valid     <= 1'b1;
        poll.raw_level <= level;
        poll.now_ms    <= at;
        @(posedge clk);
        while (!poll.ready)
            @(posedge clk);
        polls_sent++;
        gap = steady_source ? 0 : idle_length();
        if (gap != 0)
        begin
            poll.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid and wait until every predicted report has come back.
    task automatic wait_idle();
        poll.valid <= 1'b0;
        @(posedge clk);
        while (awaiting != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0]  value);
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
    endtask

    // Write all four registers back to back while the block is idle.
    task automatic apply_setting(input logic pol, input logic [MS_W-1:0] deb,
                                 input logic [MS_W-1:0] hold, input logic [MS_W-1:0] gap);
        wait_idle();
        cfg.valid <= 1'b1;
        write_reg(REG_ACTIVE_HIGH, {{(CFG_DATA_W-1){1'b0}}, pol});
        write_reg(REG_DEBOUNCE_MS, deb);
        write_reg(REG_HOLD_MS, hold);
        write_reg(REG_GAP_MS, gap);
        cfg.valid <= 1'b0;
        pol_set      = pol;
        debounce_set = 32'(deb);
        hold_set     = 32'(hold);
        gap_set      = 32'(gap);
        settings_applied++;
    endtask

    // One slice of button life: mostly a clean press with random timing,
    // sometimes raw noise with jumps back in time or anywhere in the range.
    task automatic button_episode();
        int unsigned       roll;
        int unsigned       n;
        int unsigned       k;
        int unsigned       dur;
        int unsigned       lead;
        int unsigned       mid;
        int unsigned       settle;
        logic [TIME_W-1:0] start;
        roll = $urandom_range(0, 99);
        if (roll < 12)
        begin
            n = $urandom_range(1, 3);
            for (k = 0; k < n; k++)
            begin
                case ($urandom_range(0, 2))
                    0:       wall_ms = wall_ms + $urandom_range(0, 400);
                    1:       wall_ms = wall_ms - $urandom_range(1, 3000);
                    default: wall_ms = $urandom();
                endcase
                send_poll(1'($urandom_range(0, 1)), wall_ms);
            end
        end
        else
        begin
            dur  = press_length();
            // short leads chain presses into one sequence, long ones split it
            if ($urandom_range(0, 9) < 7)
                lead = $urandom_range(1, gap_set / 2 + 1);
            else
                lead = $urandom_range(1, gap_set + 200);
            start = wall_ms + lead;
            send_poll(pin_for(1'b1), start);
            n   = $urandom_range(0, 2);
            mid = 0;
            for (k = 0; k < n; k++)
            begin
                mid = $urandom_range(mid, dur);
                send_poll(pin_for(1'b1), start + mid);
            end
            wall_ms = start + dur;
            send_poll(pin_for(1'b0), wall_ms);
            // idle polls around the report deadline
            if ($urandom_range(0, 9) < 4)
            begin
                n = $urandom_range(1, 2);
                for (k = 0; k < n; k++)
                begin
                    case ($urandom_range(0, 3))
                        0:       settle = gap_set;
                        1:       settle = gap_set + 1;
                        default: settle = gap_set + 2 + $urandom_range(0, 600);
                    endcase
                    wall_ms = wall_ms + settle;
                    send_poll(pin_for(1'b0), wall_ms);
                end
            end
        end
    endtask

    // Stall the result side for a long stretch while polls keep coming,
    // then stop sending until everything has drained.
    task automatic pressure_burst();
        int target;
        steady_source = 1'b1;
        long_holdoff  = 1'b1;
        target = polls_sent + 40;
        while (polls_sent < target)
            button_episode();
        steady_source = 1'b0;
        wait_idle();
    endtask

    // Result side: random ready with runs and gaps; long hold-off on request.
    initial
    begin : sink_side
        int unsigned run;
        int unsigned gap;
        result.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (long_holdoff)
            begin
                result.ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge clk);
                long_holdoff = 1'b0;
            end
            result.ready <= 1'b1;
            run = $urandom_range(1, 24);
            repeat (run) @(posedge clk);
            gap = steady_sink ? 0 : idle_length();
            if (gap != 0)
            begin
                result.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    initial
    begin : watchdog
        #5000000;
        $display("testbench: done, errors");
        $finish;
    end

    initial
    begin : source_side
        int k;
        int phase;
        int target;
        bit burst_done;
        rst_n          <= 1'b0;
        poll.valid     <= 1'b0;
        poll.raw_level <= 1'b0;
        poll.now_ms    <= '0;
        cfg.valid      <= 1'b0;
        cfg.index      <= REG_ACTIVE_HIGH;
        cfg.data       <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset setting (high means pressed).
        // Alternate press and release with time jumping back to the same press
        // time at each press: every change re-measures the same click, so the
        // count saturates, then one late poll reports it.
        for (k = 0; k < 10; k++)
            send_poll(k % 2 == 0, (k % 2 == 0) ? 32'd1000 : 32'd1100);
        send_poll(1'b0, 32'd1401);
        // press exactly at the debounce limit: ignored
        send_poll(1'b1, 32'd2000);
        send_poll(1'b0, 32'd2050);
        // a hold then a click, both reported by the same poll
        send_poll(1'b1, 32'd3000);
        send_poll(1'b0, 32'd4000);
        send_poll(1'b1, 32'd4100);
        send_poll(1'b0, 32'd4200);
        send_poll(1'b0, 32'd4501);
        // click ending near the top of time: deadline wraps, reported at once
        send_poll(1'b1, 32'hFFFF_FE00);
        send_poll(1'b0, 32'hFFFF_FF00);
        // press across the wrap: off time not later than on time, missed
        send_poll(1'b1, 32'hFFFF_FFFF);
        send_poll(1'b0, 32'h0000_0000);
        // one past the debounce limit: a click, reported one past the gap
        send_poll(1'b1, 32'd5000);
        send_poll(1'b0, 32'd5051);
        send_poll(1'b0, 32'd5352);
        wall_ms = 32'd6000;

        // Random part, one register setting per phase.
        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: apply_setting(1'b1, 16'd50, 16'd1000, 16'd300);
                1: apply_setting(1'b0, 16'd0, 16'd0, 16'd0);
                2: apply_setting(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                3: apply_setting(1'b0, 16'd20, 16'd200, 16'd100);
                4: apply_setting(1'b1, 16'd300, 16'd120, 16'd40);
                default:
                begin
                    debounce_set = $urandom_range(0, 400);
                    apply_setting(1'($urandom_range(0, 1)), MS_W'(debounce_set),
                                  MS_W'($urandom_range(debounce_set + 1,
                                                       debounce_set + 3000)),
                                  MS_W'($urandom_range(0, 1500)));
                end
            endcase
            // move the time base so every bit of the time field toggles,
            // and run one phase straight across the wrap
            if (phase == 2 || phase == 5)
                wall_ms = $urandom();
            else if (phase == 6)
                wall_ms = 32'hFFFF_FFFF - $urandom_range(0, 20000);
            // phase 3 runs with no idling on either side
            steady_source = (phase == 3);
            steady_sink   = (phase == 3);
            burst_done    = 1'b0;
            target = polls_sent + PHASE_POLLS;
            while (polls_sent < target)
            begin
                // one long stall halfway through the phase
                if ((phase == 0 || phase == 5) && !burst_done &&
                    polls_sent >= target - PHASE_POLLS / 2)
                begin
                    burst_done = 1'b1;
                    pressure_burst();
                end
                button_episode();
            end
            steady_source = 1'b0;
            steady_sink   = 1'b0;
        end

        wait_idle();
        repeat (8) @(posedge clk);
        $display("summary: %0d poll words over %0d register settings, %0d results checked",
                 polls_sent, settings_applied, checked);
        $display("summary: %0d click reports, %0d hold reports, %0d carrying both",
                 click_reports, hold_reports, dual_reports);
        if (errors == 0 && awaiting == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
design/mchc_pkg.sv
design/mchc_if.sv
design/multi_click_hold_classifier.sv
design/mchc_checker.sv
bench/mchc_report_checker.sv
bench/testbench.sv
